// ----- sv/sdtq_pkg.sv -----
package sdtq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int TAG_BITS_DEF  = 32;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int HANDLE_W = 4;
    localparam int OTAG_W   = 32;
    localparam int OTIME_W  = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHED_REL = 2'd0,
        CMD_SCHED_ABS = 2'd1,
        CMD_CANCEL    = 2'd2,
        CMD_EXPIRE    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SCHEDULED = 3'd0,
        ST_FULL      = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE_DUE  = 3'd5
    } status_t;

endpackage

// ----- sv/sdtq_cmp.sv -----
module sdtq_cmp #(
    parameter int TIME_BITS = 48
) (
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output logic                 a_lt_b,
    output logic [TIME_BITS-1:0] a_sub_b
);
    // The one shared subtractor: the borrow gives the compare.
    logic [TIME_BITS:0] diff;

    assign diff    = {1'b0, a} - {1'b0, b};
    assign a_lt_b  = diff[TIME_BITS];
    assign a_sub_b = diff[TIME_BITS-1:0];
endmodule

// ----- sv/sorted_deadline_timer_queue_unit.sv -----
// A schedule searches for the lowest free slot, walks the order list to its place, shifts the
// later entries up and writes the entry before it answers; a full queue answers without search.
// A cancel walks the order list to the handle and shifts the later entries down. An expiry
// shifts the order list one place a cycle for each due entry, then reports the next deadline.
// One request at a time; in_stall stays high until the last result is taken.
// Reset clears control, slot valid bits and the entry count; the stores are undefined.
module sorted_deadline_timer_queue_unit #(
    parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS  = sdtq_pkg::TAG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sdtq_pkg::CMD_W-1:0]    cmd,
    input  logic [TIME_BITS-1:0]          now_time,
    input  logic [TIME_BITS-1:0]          when_time,
    input  logic [TAG_BITS-1:0]           task_tag,
    input  logic [sdtq_pkg::HANDLE_W-1:0] cancel_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sdtq_pkg::STATUS_W-1:0] status,
    output logic [sdtq_pkg::HANDLE_W-1:0] slot_handle,
    output logic [sdtq_pkg::OTAG_W-1:0]   expired_tag,
    output logic                          reload_timer,
    output logic [sdtq_pkg::OTIME_W-1:0]  timer_interval,
    output logic                          last
);
    import sdtq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_FREE, S_FIND, S_SHIFT_UP, S_WRITE,
        S_CFIND, S_SHIFT_DN, S_EHEAD, S_EEMIT, S_EOUT, S_EFIN, S_OUT
    } state_t;

    // Request latched on acceptance.
    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [TIME_BITS-1:0] now_reg, when_reg, dl_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [HANDLE_W-1:0]  handle_reg;

    // Stores. Order list and deadlines are memories walked one place a cycle.
    logic [TIME_BITS-1:0] dl_mem [DEPTH];
    logic [TAG_BITS-1:0]  tag_mem [DEPTH];
    logic [IW-1:0]        ord_mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [CW-1:0]        count_reg;

    logic [CW-1:0]        pos_reg;     // walking position in the order list
    logic [CW-1:0]        ptr_reg;     // shift pointer
    logic [IW-1:0]        slot_reg;
    logic                 after_emit_reg;
    logic                 expired_any_reg;

    // Shared subtractor operands.
    logic [TIME_BITS-1:0] cmp_a, cmp_b, cmp_d;
    logic                 cmp_lt;

    sdtq_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
        .a(cmp_a), .b(cmp_b), .a_lt_b(cmp_lt), .a_sub_b(cmp_d)
    );

    // Lookups through the order list (combinational within small depth).
    logic [IW-1:0]        ord_at_pos;
    logic [TIME_BITS-1:0] dl_at_pos;
    assign ord_at_pos = ord_mem[pos_reg[IW-1:0]];
    assign dl_at_pos  = dl_mem[ord_at_pos];

    always_comb
    begin
        cmp_a = dl_at_pos;
        cmp_b = dl_reg;
        case (state_reg)
            S_PREP:
            begin
                cmp_a = when_reg;
                cmp_b = now_reg;
            end
            S_FIND:
            begin
                cmp_a = dl_at_pos;
                cmp_b = dl_reg;
            end
            S_EHEAD, S_OUT:
            begin
                cmp_a = now_reg;
                cmp_b = dl_at_pos;
            end
            S_WRITE:
            begin
                cmp_a = dl_reg;
                cmp_b = now_reg;
            end
            S_EFIN:
            begin
                cmp_a = dl_at_pos;
                cmp_b = now_reg;
            end
            default:
            begin
                cmp_a = dl_at_pos;
                cmp_b = dl_reg;
            end
        endcase
    end

    logic [TIME_BITS:0] rel_sum;
    assign rel_sum = {1'b0, now_reg} + {1'b0, when_reg};

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            dl_mem[slot_reg]  <= dl_reg;
            tag_mem[slot_reg] <= tag_reg;
        end
        if (state_reg == S_SHIFT_UP && ptr_reg > pos_reg)
            ord_mem[ptr_reg[IW-1:0]] <= ord_mem[ptr_reg[IW-1:0] - IW'(1)];
        else if (state_reg == S_WRITE)
            ord_mem[pos_reg[IW-1:0]] <= slot_reg;
        else if (state_reg == S_SHIFT_DN && (ptr_reg + CW'(1)) < count_reg)
            ord_mem[ptr_reg[IW-1:0]] <= ord_mem[ptr_reg[IW-1:0] + IW'(1)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            out_valid       <= 1'b0;
            pos_reg         <= '0;
            ptr_reg         <= '0;
            slot_reg        <= '0;
            after_emit_reg  <= 1'b0;
            expired_any_reg <= 1'b0;
            cmd_reg         <= CMD_SCHED_REL;
            status          <= ST_SCHEDULED;
            slot_handle     <= '0;
            expired_tag     <= '0;
            reload_timer    <= 1'b0;
            timer_interval  <= '0;
            last            <= 1'b0;
            now_reg         <= '0;
            when_reg        <= '0;
            dl_reg          <= '0;
            tag_reg         <= '0;
            handle_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg         <= cmd_t'(cmd);
                        now_reg         <= now_time;
                        when_reg        <= when_time;
                        tag_reg         <= task_tag;
                        handle_reg      <= cancel_handle;
                        pos_reg         <= '0;
                        slot_reg        <= '0;
                        expired_any_reg <= 1'b0;
                        case (cmd_t'(cmd))
                            CMD_CANCEL: state_reg <= S_CFIND;
                            CMD_EXPIRE: state_reg <= S_EHEAD;
                            default:    state_reg <= S_PREP;
                        endcase
                    end
                end
                S_PREP:
                begin
                    if (cmd_reg == CMD_SCHED_REL)
                        dl_reg <= rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];
                    else
                        dl_reg <= cmp_lt ? now_reg : when_reg;
                    if (count_reg >= CW'(DEPTH))
                    begin
                        status         <= ST_FULL;
                        slot_handle    <= '0;
                        expired_tag    <= '0;
                        reload_timer   <= 1'b0;
                        timer_interval <= '0;
                        last           <= 1'b1;
                        out_valid      <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else
                        state_reg <= S_FREE;
                end
                S_FREE:
                begin
                    // Lowest free slot, one slot tested a cycle.
                    if (!valid_reg[slot_reg])
                        state_reg <= S_FIND;
                    else
                        slot_reg <= slot_reg + IW'(1);
                end
                S_FIND:
                begin
                    if (pos_reg < count_reg && cmp_lt)
                        pos_reg <= pos_reg + CW'(1);
                    else
                    begin
                        ptr_reg   <= count_reg;
                        state_reg <= S_SHIFT_UP;
                    end
                end
                S_SHIFT_UP:
                begin
                    if (ptr_reg > pos_reg)
                        ptr_reg <= ptr_reg - CW'(1);
                    else
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    valid_reg[slot_reg] <= 1'b1;
                    count_reg           <= count_reg + CW'(1);
                    status              <= ST_SCHEDULED;
                    slot_handle         <= HANDLE_W'(slot_reg);
                    expired_tag         <= '0;
                    reload_timer        <= (pos_reg == '0);
                    // The subtractor gives dl - now; a borrow means the deadline has passed.
                    timer_interval      <= (pos_reg == '0 && !cmp_lt) ?
                                           OTIME_W'(cmp_d) : '0;
                    last                <= 1'b1;
                    out_valid           <= 1'b1;
                    state_reg           <= S_OUT;
                end
                S_CFIND:
                begin
                    if (32'(handle_reg) >= DEPTH || !valid_reg[handle_reg[IW-1:0]])
                    begin
                        status         <= ST_NOT_FOUND;
                        slot_handle    <= handle_reg;
                        expired_tag    <= '0;
                        reload_timer   <= 1'b0;
                        timer_interval <= '0;
                        last           <= 1'b1;
                        out_valid      <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else if (pos_reg < count_reg &&
                             ord_at_pos != handle_reg[IW-1:0])
                        pos_reg <= pos_reg + CW'(1);
                    else
                    begin
                        valid_reg[handle_reg[IW-1:0]] <= 1'b0;
                        if (pos_reg < count_reg)
                        begin
                            ptr_reg   <= pos_reg;
                            state_reg <= S_SHIFT_DN;
                        end
                        else
                        begin
                            status         <= ST_NOT_FOUND;
                            slot_handle    <= handle_reg;
                            expired_tag    <= '0;
                            reload_timer   <= 1'b0;
                            timer_interval <= '0;
                            last           <= 1'b1;
                            out_valid      <= 1'b1;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_SHIFT_DN:
                begin
                    if ((ptr_reg + CW'(1)) < count_reg)
                        ptr_reg <= ptr_reg + CW'(1);
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        if (cmd_reg == CMD_EXPIRE)
                        begin
                            pos_reg   <= '0;
                            state_reg <= S_EHEAD;
                        end
                        else
                        begin
                            status         <= ST_CANCELLED;
                            slot_handle    <= handle_reg;
                            expired_tag    <= '0;
                            reload_timer   <= 1'b0;
                            timer_interval <= '0;
                            last           <= 1'b1;
                            out_valid      <= 1'b1;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_EHEAD:
                begin
                    // Head due when now >= deadline, that is not (now < dl).
                    if (count_reg != '0 && !cmp_lt)
                    begin
                        if (after_emit_reg)
                        begin
                            // Another entry is due, so the held one is not final.
                            out_valid <= 1'b1;
                            state_reg <= S_EOUT;
                        end
                        else
                        begin
                            status          <= ST_EXPIRED;
                            slot_handle     <= HANDLE_W'(ord_at_pos);
                            expired_tag     <= OTAG_W'(tag_mem[ord_at_pos]);
                            reload_timer    <= 1'b0;
                            timer_interval  <= '0;
                            last            <= 1'b0;
                            expired_any_reg <= 1'b1;
                            state_reg       <= S_EEMIT;
                        end
                    end
                    else
                        state_reg <= S_EFIN;
                end
                S_EEMIT:
                begin
                    // Hold the expired entry until it is known whether it is final.
                    valid_reg[ord_at_pos] <= 1'b0;
                    ptr_reg               <= '0;
                    after_emit_reg        <= 1'b1;
                    state_reg             <= S_SHIFT_DN;
                end
                S_EOUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid      <= 1'b0;
                        after_emit_reg <= 1'b0;
                        state_reg      <= S_EHEAD;
                    end
                end
                S_EFIN:
                begin
                    if (!expired_any_reg)
                    begin
                        status      <= ST_NONE_DUE;
                        slot_handle <= '0;
                        expired_tag <= '0;
                    end
                    reload_timer   <= (count_reg != '0);
                    timer_interval <= (count_reg != '0 && !cmp_lt) ?
                                      OTIME_W'(cmp_d) : '0;
                    last           <= 1'b1;
                    out_valid      <= 1'b1;
                    after_emit_reg <= 1'b0;
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/sv/timer_queue_checker.sv -----
`timescale 1ns / 100ps

module timer_queue_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [sdtq_pkg::CMD_W-1:0]    cmd,
    input  logic [47:0]                   now_time,
    input  logic [47:0]                   when_time,
    input  logic [31:0]                   task_tag,
    input  logic [sdtq_pkg::HANDLE_W-1:0] cancel_handle,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [sdtq_pkg::STATUS_W-1:0] status,
    input  logic [sdtq_pkg::HANDLE_W-1:0] slot_handle,
    input  logic [31:0]                   expired_tag,
    input  logic                          reload_timer,
    input  logic [47:0]                   timer_interval,
    input  logic                          last,
    output int                            fail_count,
    output int                            pending_count
);
    import sdtq_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [47:0] TIME_MAX = '1;

    typedef struct packed {
        status_t     st;
        logic [3:0]  slot;
        logic [31:0] tag;
        logic        reload;
        logic [47:0] interval;
        logic        fin;
    } timer_result_t;

    timer_result_t expected_results[$];

    logic [47:0] deadlines [SLOTS];
    logic [31:0] tags      [SLOTS];
    logic        occupied  [SLOTS];
    logic [3:0]  order     [SLOTS];
    int          count;

    function automatic timer_result_t make_result(status_t st, logic [3:0] slot,
                                                  logic [31:0] tag, logic rl,
                                                  logic [47:0] iv);
        timer_result_t r;
        r.st = st; r.slot = slot; r.tag = tag; r.reload = rl;
        r.interval = iv; r.fin = 1'b0;
        return r;
    endfunction

    task automatic drop_position(int pos);
        occupied[order[pos]] = 1'b0;
        for (int i = pos; i < count - 1; i++)
            order[i] = order[i + 1];
        count--;
    endtask

    task automatic insert_event(logic [47:0] dl, logic [47:0] now_v, logic [31:0] tg);
        int slot;
        int pos;
        slot = 0;
        pos = 0;
        if (count >= SLOTS) begin
            expected_results.push_back(make_result(ST_FULL, '0, '0, 1'b0, '0));
            return;
        end
        while (occupied[slot])
            slot++;
        while (pos < count && deadlines[order[pos]] < dl)
            pos++;
        for (int i = count; i > pos; i--)
            order[i] = order[i - 1];
        order[pos] = slot[3:0];
        deadlines[slot] = dl;
        tags[slot] = tg;
        occupied[slot] = 1'b1;
        count++;
        expected_results.push_back(make_result(ST_SCHEDULED, slot[3:0], '0, pos == 0,
            (pos == 0 && dl > now_v) ? dl - now_v : 48'd0));
    endtask

    task automatic predict_request(cmd_t c, logic [47:0] now_v, logic [47:0] when_v,
                                   logic [31:0] tg, logic [3:0] h);
        logic [48:0] sum;
        int emitted;
        int pos;
        logic [47:0] hd;
        emitted = 0;
        case (c)
            CMD_SCHED_REL:
            begin
                sum = {1'b0, now_v} + {1'b0, when_v};
                insert_event(sum[48] ? TIME_MAX : sum[47:0], now_v, tg);
            end
            CMD_SCHED_ABS:
                insert_event(when_v < now_v ? now_v : when_v, now_v, tg);
            CMD_CANCEL:
            begin
                pos = 0;
                if (occupied[h]) begin
                    while (order[pos] != h)
                        pos++;
                    drop_position(pos);
                    expected_results.push_back(make_result(ST_CANCELLED, h, '0, 1'b0, '0));
                end
                else
                    expected_results.push_back(make_result(ST_NOT_FOUND, h, '0, 1'b0, '0));
            end
            default:
            begin
                while (count > 0 && deadlines[order[0]] <= now_v) begin
                    expected_results.push_back(make_result(ST_EXPIRED, order[0],
                                                           tags[order[0]], 1'b0, '0));
                    emitted++;
                    drop_position(0);
                end
                if (emitted == 0)
                    expected_results.push_back(make_result(ST_NONE_DUE, '0, '0, 1'b0, '0));
                if (count > 0) begin
                    hd = deadlines[order[0]];
                    expected_results[$].reload = 1'b1;
                    expected_results[$].interval = hd > now_v ? hd - now_v : 48'd0;
                end
            end
        endcase
        expected_results[$].fin = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t e;
        if (!rst_n) begin
            expected_results.delete();
            count = 0;
            fail_count <= 0;
            for (int i = 0; i < SLOTS; i++)
                occupied[i] = 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result, status %0d", status);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_results.pop_front();
                    if (status !== e.st || slot_handle !== e.slot ||
                        expired_tag !== e.tag || reload_timer !== e.reload ||
                        timer_interval !== e.interval || last !== e.fin) begin
                        if (status !== e.st)
                            $error("status: expected %0d, got %0d", e.st, status);
                        if (slot_handle !== e.slot)
                            $error("slot_handle: expected %0d, got %0d", e.slot, slot_handle);
                        if (expired_tag !== e.tag)
                            $error("expired_tag: expected %h, got %h", e.tag, expired_tag);
                        if (reload_timer !== e.reload)
                            $error("reload_timer: expected %0d, got %0d", e.reload,
                                   reload_timer);
                        if (timer_interval !== e.interval)
                            $error("timer_interval: expected %0d, got %0d", e.interval,
                                   timer_interval);
                        if (last !== e.fin)
                            $error("last: expected %0d, got %0d", e.fin, last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Prediction follows the result check, so a same-edge request
            // cannot satisfy its own expectation.
            if (in_valid && !in_stall)
                predict_request(cmd_t'(cmd), now_time, when_time, task_tag, cancel_handle);
        end
    end

    assign pending_count = expected_results.size();
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import sdtq_pkg::*;

    // Cycles without any handshake before the run is declared hung. The
    // longest honest gap is a schedule into a nearly full queue, stretched
    // by random stalls, so this limit is many times that gap.
    localparam int HANG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [47:0] now_time;
    logic [47:0] when_time;
    logic [31:0] task_tag;
    logic [3:0]  cancel_handle;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [3:0]  slot_handle;
    logic [31:0] expired_tag;
    logic        reload_timer;
    logic [47:0] timer_interval;
    logic        last;
    int          fail_count;
    int          pending_count;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles = 0;

    // A running clock of the software being modelled; requests mostly move
    // it forward so that deadlines fall both ahead and behind.
    logic [47:0] sim_now;

    sorted_deadline_timer_queue_unit dut (.*);

    timer_queue_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: counts cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it. The
    // idle gap before it depends on the phase.
    task automatic send_request(cmd_t c, logic [47:0] nw, logic [47:0] wh,
                                logic [31:0] tg, logic [3:0] h);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid      <= 1'b1;
        cmd           <= c;
        now_time      <= nw;
        when_time     <= wh;
        task_tag      <= tg;
        cancel_handle <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        // The block stays busy after taking a request anyway.
        @(posedge clk);
    endtask

    // Random requests: mostly schedules and expiries around a moving clock,
    // so that the queue fills, drains and sees both kinds of deadline.
    task automatic random_request();
        int pick;
        logic [47:0] wh;
        pick = $urandom_range(99);
        if ($urandom_range(3) == 0)
            sim_now = sim_now + 48'($urandom_range(2000));
        case ($urandom_range(5))
            0: wh = 48'({$urandom, $urandom});
            1: wh = 48'($urandom_range(20));
            default: wh = 48'($urandom_range(3000));
        endcase
        if (pick < 40)
            send_request(CMD_SCHED_REL, sim_now, wh, $urandom, 4'($urandom));
        else if (pick < 60)
            send_request(CMD_SCHED_ABS, sim_now, sim_now + wh - 48'd1500, $urandom,
                         4'($urandom));
        else if (pick < 75)
            send_request(CMD_CANCEL, sim_now, wh, $urandom, 4'($urandom));
        else if (pick < 97)
            send_request(CMD_EXPIRE, sim_now, wh, $urandom, 4'($urandom));
        else
            send_request(cmd_t'($urandom_range(3)), 48'({$urandom, $urandom}),
                         48'({$urandom, $urandom}), $urandom, 4'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_EXPIRE;
        now_time = '0;
        when_time = '0;
        task_tag = '0;
        cancel_handle = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        sim_now = 48'd1000;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty queue cases, then the extremes.
        send_request(CMD_EXPIRE, 48'd0, 48'd0, 32'd0, 4'd0);
        send_request(CMD_CANCEL, 48'd0, 48'd0, 32'd0, 4'd15);
        // Saturating relative deadline.
        send_request(CMD_SCHED_REL, '1, '1, '1, 4'd0);
        // Absolute deadline in the past is clamped to now.
        send_request(CMD_SCHED_ABS, 48'd500, 48'd10, 32'hA5A5_5A5A, 4'd0);
        // Equal deadlines: the newer one goes in front.
        send_request(CMD_SCHED_ABS, 48'd100, 48'd700, 32'h1, 4'd0);
        send_request(CMD_SCHED_ABS, 48'd100, 48'd700, 32'h2, 4'd0);
        send_request(CMD_SCHED_REL, 48'd0, 48'd0, 32'h0, 4'd0);
        send_request(CMD_CANCEL, 48'd0, 48'd0, 32'd0, 4'd1);
        send_request(CMD_CANCEL, 48'd0, 48'd0, 32'd0, 4'd1);
        send_request(CMD_EXPIRE, 48'd700, 48'd0, 32'd0, 4'd0);
        // Fill the queue past capacity, then drain it in one expiry.
        for (int i = 0; i < 16; i++)
            send_request(CMD_SCHED_REL, 48'd2000, 48'($urandom_range(5000)), $urandom,
                         4'd0);
        send_request(CMD_EXPIRE, '1, 48'd0, 32'd0, 4'd0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 35 : 0;
            stall_pct     = (phase == 2) ? 60 : (phase == 3) ? 35 : 0;
            for (int n = 0; n < 71; n++)
                random_request();
            // Hold off until the block has answered everything so far.
            while (pending_count != 0)
                @(posedge clk);
        end

        while (pending_count != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
